@@ rtl/core/mlcd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlcd_pkg
// Shared constants and types of the monochrome LCD controller.
// ----------------------------------------------------------------------------
package mlcd_pkg;

   localparam int PIXEL_ROWS  = 64;
   localparam int PIXEL_COLS  = 96;
   localparam int PIXEL_COUNT = PIXEL_ROWS * PIXEL_COLS;
   localparam int ADDR_W      = $clog2(PIXEL_COUNT);

   typedef logic [ADDR_W-1:0] pix_addr_type;

   // bus function codes
   localparam logic [1:0] FUNC_CMD    = 2'd0;
   localparam logic [1:0] FUNC_STATUS = 2'd1;
   localparam logic [1:0] FUNC_WRITE  = 2'd2;
   localparam logic [1:0] FUNC_READ   = 2'd3;

   // auto-move directions
   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_RIGHT = 2'd3;

   // low command codes
   localparam logic [2:0] CMD_WORD6    = 3'd0;
   localparam logic [2:0] CMD_WORD8    = 3'd1;
   localparam logic [2:0] CMD_DISP_OFF = 3'd2;
   localparam logic [2:0] CMD_DISP_ON  = 3'd3;

   localparam logic [4:0] LAST_COL_W8 = 5'd14;
   localparam logic [4:0] LAST_COL_W6 = 5'd19;

   typedef struct packed {
      logic       go;
      logic       write;
      logic       wide;
      logic [7:0] data;
      logic [5:0] row;
      logic [4:0] col;
   } xfer_req_type;

   typedef struct packed {
      logic       clearing;
      logic       done;
      logic [7:0] word;
   } xfer_stat_type;

   typedef struct packed {
      logic         we;
      pix_addr_type addr;
      logic         wdata;
   } mem_req_type;

endpackage
`default_nettype wire

@@ rtl/core/mlcd_pixel_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlcd_pixel_ram
// Single-port 1-bit pixel memory with registered read data.
// ----------------------------------------------------------------------------
module mlcd_pixel_ram
   import mlcd_pkg::*;
(
   input  wire logic        clock,
   input  wire mem_req_type mem_req,
   output logic             rdata
);

   logic mem_array [PIXEL_COUNT];

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_array[mem_req.addr] <= mem_req.wdata;
      end
      rdata <= mem_array[mem_req.addr];
   end

endmodule
`default_nettype wire

@@ rtl/core/mlcd_bit_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlcd_bit_engine
// Bit-serial word transfer to and from the pixel RAM, one pixel per cycle,
// and the clearing sweep after reset.
// ----------------------------------------------------------------------------
module mlcd_bit_engine
   import mlcd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire xfer_req_type  xfer_req,
   output xfer_stat_type      xfer_stat
);

   typedef enum logic [1:0] {E_CLEAR, E_IDLE, E_RUN, E_DONE} eng_state_type;

   eng_state_type state_ff;
   pix_addr_type  clr_addr_ff;
   pix_addr_type  addr_ff;
   logic [7:0]    x_ff;
   logic [3:0]    cnt_ff;
   logic [7:0]    data_sr_ff;
   logic [7:0]    word_sr_ff;
   logic          wr_ff;
   logic          rd_pend_ff;
   logic          rd_mask_ff;

   pix_addr_type  row_base_in;
   logic [7:0]    x0_in;
   logic          in_range;
   logic          issue;
   logic          rdata;
   mem_req_type   mem_req;

   assign row_base_in = pix_addr_type'({xfer_req.row, 6'b0})
                      + pix_addr_type'({xfer_req.row, 5'b0});
   assign x0_in       = xfer_req.wide ? {xfer_req.col, 3'b0}
                      : ({1'b0, xfer_req.col, 2'b0} + {2'b0, xfer_req.col, 1'b0});
   assign in_range    = (x_ff < 8'(PIXEL_COLS));
   assign issue       = (state_ff == E_RUN) && (cnt_ff != 4'd0);

   always_comb begin
      if (state_ff == E_CLEAR) begin
         mem_req.we    = 1'b1;
         mem_req.addr  = clr_addr_ff;
         mem_req.wdata = 1'b0;
      end else begin
         mem_req.we    = issue && wr_ff && in_range;
         mem_req.addr  = addr_ff;
         mem_req.wdata = data_sr_ff[7];
      end
   end

   mlcd_pixel_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= E_CLEAR;
         clr_addr_ff <= '0;
         rd_pend_ff  <= 1'b0;
      end else begin
         rd_pend_ff <= issue && !wr_ff;
         rd_mask_ff <= in_range;
         if (rd_pend_ff) begin
            word_sr_ff <= {word_sr_ff[6:0], rd_mask_ff & rdata};
         end
         unique case (state_ff)
            E_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
               if (clr_addr_ff == pix_addr_type'(PIXEL_COUNT - 1)) begin
                  state_ff <= E_IDLE;
               end
            end
            E_IDLE: begin
               if (xfer_req.go) begin
                  state_ff   <= E_RUN;
                  addr_ff    <= row_base_in + pix_addr_type'(x0_in);
                  x_ff       <= x0_in;
                  cnt_ff     <= xfer_req.wide ? 4'd8 : 4'd6;
                  data_sr_ff <= xfer_req.wide ? xfer_req.data
                                              : {xfer_req.data[5:0], 2'b0};
                  wr_ff      <= xfer_req.write;
                  word_sr_ff <= '0;
               end
            end
            E_RUN: begin
               if (issue) begin
                  addr_ff    <= addr_ff + 1'b1;
                  x_ff       <= x_ff + 8'd1;
                  cnt_ff     <= cnt_ff - 4'd1;
                  data_sr_ff <= {data_sr_ff[6:0], 1'b0};
               end else begin
                  state_ff <= E_DONE;
               end
            end
            E_DONE: begin
               state_ff <= E_IDLE;
            end
            default: begin
               state_ff <= E_IDLE;
            end
         endcase
      end
   end

   assign xfer_stat.clearing = (state_ff == E_CLEAR);
   assign xfer_stat.done     = (state_ff == E_DONE);
   assign xfer_stat.word     = word_sr_ff;

endmodule
`default_nettype wire

@@ rtl/core/mono_lcd_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mono_lcd_controller
// 96x64 monochrome LCD controller: command, status and buffered data
// accesses over a command-style bus, pixels held in a bit-wide RAM.
//
//   channel  ports                                      handshake
//   request  req_func, req_data_byte                    start & !busy
//   response rsp_read_data, rsp_display_on,             rsp_strobe, 1 cycle
//            rsp_contrast_level
//
// Command and status beats: strobe in the cycle after accept, next beat may
// be taken in that same cycle.
// Data beats: one pixel per cycle through the single RAM port; w = 8 or 6
// pixels pass in E_RUN, then E_DONE, then strobe; busy holds accept till then.
// After reset the RAM is swept to zero, all 6144 pixels, with busy high.
// Responses cannot be stalled.
// ----------------------------------------------------------------------------
module mono_lcd_controller
   import mlcd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [1:0] req_func,
   input  wire logic [7:0] req_data_byte,
   output logic            rsp_strobe,
   output logic [7:0]      rsp_read_data,
   output logic            rsp_display_on,
   output logic [5:0]      rsp_contrast_level
);

   typedef enum logic {T_IDLE, T_XFER} top_state_type;

   top_state_type state_ff;
   logic [5:0]    row_ff;
   logic [4:0]    col_ff;
   logic          eight_ff;
   logic [1:0]    dir_ff;
   logic          enabled_ff;
   logic [7:0]    latch_ff;
   logic [5:0]    contrast_ff;
   logic          xfer_rd_ff;
   logic          strobe_ff;
   logic [7:0]    rsp_data_ff;

   logic          accept;
   logic [4:0]    last_col;
   logic [4:0]    col_inc;
   logic [5:0]    row_in;
   logic [4:0]    col_in;
   logic [7:0]    status_byte;
   xfer_req_type  xfer_req;
   xfer_stat_type xfer_stat;

   assign busy     = (state_ff != T_IDLE) || xfer_stat.clearing;
   assign accept   = start && !busy;
   assign last_col = eight_ff ? LAST_COL_W8 : LAST_COL_W6;
   assign col_inc  = col_ff + 5'd1;
   assign status_byte = {1'b0, eight_ff, enabled_ff, 3'b0, dir_ff[1], dir_ff[0]};

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      unique case (dir_ff)
         DIR_UP:    row_in = row_ff - 6'd1;
         DIR_DOWN:  row_in = row_ff + 6'd1;
         DIR_LEFT:  col_in = (col_ff == 5'd0) ? last_col : col_ff - 5'd1;
         DIR_RIGHT: col_in = (col_inc == last_col + 5'd1) ? 5'd0 : col_inc;
         default:   row_in = row_ff;
      endcase
   end

   assign xfer_req.go    = accept && req_func[1];
   assign xfer_req.write = (req_func == FUNC_WRITE);
   assign xfer_req.wide  = eight_ff;
   assign xfer_req.data  = req_data_byte;
   assign xfer_req.row   = row_ff;
   assign xfer_req.col   = col_ff;

   mlcd_bit_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .xfer_req  (xfer_req),
      .xfer_stat (xfer_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= T_IDLE;
         row_ff      <= '0;
         col_ff      <= '0;
         eight_ff    <= 1'b1;
         dir_ff      <= DIR_DOWN;
         enabled_ff  <= 1'b1;
         latch_ff    <= '0;
         contrast_ff <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         unique case (state_ff)
            T_IDLE: begin
               if (accept) begin
                  unique case (req_func)
                     FUNC_CMD: begin
                        strobe_ff   <= 1'b1;
                        rsp_data_ff <= '0;
                        priority if (req_data_byte[7:5] == 3'b001) begin
                           col_ff <= req_data_byte[4:0];
                        end else if (req_data_byte[7:6] == 2'b10) begin
                           row_ff <= req_data_byte[5:0];
                        end else if (req_data_byte[7:6] == 2'b11) begin
                           contrast_ff <= ~req_data_byte[5:0];
                        end else if (req_data_byte[7:3] == 5'd0) begin
                           priority if (req_data_byte[2:0] == CMD_WORD6) begin
                              eight_ff <= 1'b0;
                           end else if (req_data_byte[2:0] == CMD_WORD8) begin
                              eight_ff <= 1'b1;
                           end else if (req_data_byte[2:0] == CMD_DISP_OFF) begin
                              enabled_ff <= 1'b0;
                           end else if (req_data_byte[2:0] == CMD_DISP_ON) begin
                              enabled_ff <= 1'b1;
                           end else begin
                              dir_ff <= req_data_byte[1:0];
                           end
                        end
                     end
                     FUNC_STATUS: begin
                        strobe_ff   <= 1'b1;
                        rsp_data_ff <= status_byte;
                     end
                     FUNC_WRITE, FUNC_READ: begin
                        state_ff   <= T_XFER;
                        xfer_rd_ff <= (req_func == FUNC_READ);
                     end
                     default: begin
                        state_ff <= T_IDLE;
                     end
                  endcase
               end
            end
            T_XFER: begin
               if (xfer_stat.done) begin
                  state_ff  <= T_IDLE;
                  strobe_ff <= 1'b1;
                  row_ff    <= row_in;
                  col_ff    <= col_in;
                  if (xfer_rd_ff) begin
                     rsp_data_ff <= latch_ff;
                     latch_ff    <= xfer_stat.word;
                  end else begin
                     rsp_data_ff <= '0;
                  end
               end
            end
            default: begin
               state_ff <= T_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_read_data      = rsp_data_ff;
   assign rsp_display_on     = enabled_ff;
   assign rsp_contrast_level = contrast_ff;

endmodule
`default_nettype wire

@@ rtl/core/mlcd_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlcd_checker
// Port-level checks of the LCD controller, bound to the top level.
// ----------------------------------------------------------------------------
module mlcd_checker
   import mlcd_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic [1:0] req_func,
   input wire logic [7:0] req_data_byte,
   input wire logic       rsp_strobe,
   input wire logic [7:0] rsp_read_data,
   input wire logic [5:0] rsp_contrast_level
);

   logic beat_in;
   assign beat_in = start && !busy;

   a_short_rsp: assert property (@(posedge clock) disable iff (reset)
      beat_in && !req_func[1] |=> rsp_strobe && !busy)
      else $error("command or status beat without prompt response");

   a_data_busy: assert property (@(posedge clock) disable iff (reset)
      beat_in && req_func[1] |=> busy && !rsp_strobe)
      else $error("data beat did not hold busy");

   a_status_fmt: assert property (@(posedge clock) disable iff (reset)
      beat_in && (req_func == FUNC_STATUS) |=>
         (rsp_read_data[7] == 1'b0) && (rsp_read_data[4:2] == 3'b0))
      else $error("status byte has stray bits");

   a_contrast: assert property (@(posedge clock) disable iff (reset)
      beat_in && (req_func == FUNC_CMD) && (req_data_byte[7:6] == 2'b11) |=>
         rsp_contrast_level == ~$past(req_data_byte[5:0]))
      else $error("contrast not taken from command");

endmodule

bind mono_lcd_controller mlcd_checker u_mlcd_checker (.*);
`default_nettype wire
